FILE: hdl/r2y_pkg.sv
package r2y_pkg;

  // Default frame limits, handed to the top level as parameter defaults.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Field widths.
  localparam int COMP_W        = 8;
  localparam int SIZE_W        = 13;
  localparam int LSTRIDE_W     = 13;
  localparam int CSTRIDE_W     = 12;
  localparam int LUMA_ADDR_W   = 24;
  localparam int CHROMA_ADDR_W = 22;
  localparam int DIM_W         = 14;
  localparam int PAIR_W        = COMP_W + 1;
  localparam int QUAD_W        = COMP_W + 2;
  localparam int MATH_W        = 16;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Register reset values.
  localparam logic [SIZE_W-1:0]    RST_FRAME_WIDTH   = 13'd640;
  localparam logic [SIZE_W-1:0]    RST_FRAME_HEIGHT  = 13'd480;
  localparam logic [LSTRIDE_W-1:0] RST_LUMA_STRIDE   = 13'd640;
  localparam logic [CSTRIDE_W-1:0] RST_CHROMA_STRIDE = 12'd320;

  // BT.601 integer coefficients.
  localparam logic [MATH_W-1:0] Y_R_COEF     = 16'd66;
  localparam logic [MATH_W-1:0] Y_G_COEF     = 16'd129;
  localparam logic [MATH_W-1:0] Y_B_COEF     = 16'd25;
  localparam logic [MATH_W-1:0] ROUND_OFS    = 16'd128;
  localparam logic [COMP_W-1:0] LUMA_OFS     = 8'd16;
  localparam logic [MATH_W-1:0] CB_R_COEF    = 16'd38;
  localparam logic [MATH_W-1:0] CB_G_COEF    = 16'd74;
  localparam logic [MATH_W-1:0] CB_B_COEF    = 16'd112;
  localparam logic [MATH_W-1:0] CR_R_COEF    = 16'd112;
  localparam logic [MATH_W-1:0] CR_G_COEF    = 16'd94;
  localparam logic [MATH_W-1:0] CR_B_COEF    = 16'd18;
  // Rounding term plus a bias of 128 in the integer part, so that the
  // arithmetic shift and the +128 become a plain unsigned bit select.
  localparam logic [MATH_W-1:0] CHROMA_BIAS  = 16'd32896;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_LUMA_STRIDE   = 2'd2,
    REG_CHROMA_STRIDE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [COMP_W-1:0]        luma;
    logic [LUMA_ADDR_W-1:0]   luma_address;
    logic                     chroma_valid;
    logic [COMP_W-1:0]        chroma_u;
    logic [COMP_W-1:0]        chroma_v;
    logic [CHROMA_ADDR_W-1:0] chroma_address;
    logic                     frame_last;
  } out_item_t;

  // Frame geometry as the datapath sees it: sizes are already clamped and
  // given as the index of the last column and row.
  typedef struct packed {
    logic [DIM_W-1:0]     width_last;
    logic [DIM_W-1:0]     height_last;
    logic [LSTRIDE_W-1:0] luma_stride;
    logic [CSTRIDE_W-1:0] chroma_stride;
  } cfg_t;

  // Horizontal pair sums as stored in the line buffer.
  typedef struct packed {
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] red;
  } pair_t;

endpackage

FILE: hdl/r2y_ram.sv
module r2y_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/r2y_cfg.sv
module r2y_cfg
  import r2y_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [SIZE_W-1:0]    frame_width_r, frame_width_nxt;
  logic [SIZE_W-1:0]    frame_height_r, frame_height_nxt;
  logic [LSTRIDE_W-1:0] luma_stride_r, luma_stride_nxt;
  logic [CSTRIDE_W-1:0] chroma_stride_r, chroma_stride_nxt;
  logic                 wr_en;
  reg_idx_t             reg_idx;
  logic [DIM_W-1:0]     fw_ext;
  logic [DIM_W-1:0]     fh_ext;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    frame_width_nxt   = frame_width_r;
    frame_height_nxt  = frame_height_r;
    luma_stride_nxt   = luma_stride_r;
    chroma_stride_nxt = chroma_stride_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:   frame_width_nxt   = pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_nxt  = pwdata[SIZE_W-1:0];
        REG_LUMA_STRIDE:   luma_stride_nxt   = pwdata[LSTRIDE_W-1:0];
        REG_CHROMA_STRIDE: chroma_stride_nxt = pwdata[CSTRIDE_W-1:0];
        default:           frame_width_nxt   = frame_width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
      luma_stride_r   <= RST_LUMA_STRIDE;
      chroma_stride_r <= RST_CHROMA_STRIDE;
    end else begin
      frame_width_r   <= frame_width_nxt;
      frame_height_r  <= frame_height_nxt;
      luma_stride_r   <= luma_stride_nxt;
      chroma_stride_r <= chroma_stride_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:   prdata = APB_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(frame_height_r);
      REG_LUMA_STRIDE:   prdata = APB_DATA_W'(luma_stride_r);
      REG_CHROMA_STRIDE: prdata = APB_DATA_W'(chroma_stride_r);
      default:           prdata = '0;
    endcase
  end

  // A size of zero acts as one, a size above the maximum as the maximum.
  assign fw_ext = DIM_W'(frame_width_r);
  assign fh_ext = DIM_W'(frame_height_r);

  always_comb begin
    if (fw_ext == '0) begin
      cfg.width_last = '0;
    end else if (fw_ext > DIM_W'(MAX_WIDTH)) begin
      cfg.width_last = DIM_W'(MAX_WIDTH - 1);
    end else begin
      cfg.width_last = fw_ext - DIM_W'(1);
    end
    if (fh_ext == '0) begin
      cfg.height_last = '0;
    end else if (fh_ext > DIM_W'(MAX_HEIGHT)) begin
      cfg.height_last = DIM_W'(MAX_HEIGHT - 1);
    end else begin
      cfg.height_last = fh_ext - DIM_W'(1);
    end
    cfg.luma_stride   = luma_stride_r;
    cfg.chroma_stride = chroma_stride_r;
  end

endmodule

FILE: hdl/r2y_chroma.sv
module r2y_chroma
  import r2y_pkg::*;
(
  input  logic              en,
  input  logic [COMP_W-1:0] avg_r,
  input  logic [COMP_W-1:0] avg_g,
  input  logic [COMP_W-1:0] avg_b,
  output logic [COMP_W-1:0] cb,
  output logic [COMP_W-1:0] cr
);

  logic [MATH_W-1:0] ar, ag, ab;
  logic [MATH_W-1:0] cb_sum, cr_sum;

  assign ar = MATH_W'(avg_r);
  assign ag = MATH_W'(avg_g);
  assign ab = MATH_W'(avg_b);

  // With the bias the sums never go negative and never pass 16 bits.
  assign cb_sum = CHROMA_BIAS + CB_B_COEF * ab - CB_R_COEF * ar - CB_G_COEF * ag;
  assign cr_sum = CHROMA_BIAS + CR_R_COEF * ar - CR_G_COEF * ag - CR_B_COEF * ab;

  assign cb = en ? cb_sum[MATH_W-1:MATH_W-COMP_W] : '0;
  assign cr = en ? cr_sum[MATH_W-1:MATH_W-COMP_W] : '0;

endmodule

FILE: hdl/rgb_to_yuv420_converter_core.sv
// Channel    Direction  Payload      Handshake
// in_        input      in_item_t    in_valid / in_stall
// out_       output     out_item_t   out_valid / out_stall
// APB        input      registers    psel, penable, pwrite, pready
//
// One pixel is accepted every clock cycle unless in_stall is high; each result
// passes through the line buffer read, conversion and output register stages.
// The pair-sum line buffer is a simple dual-port RAM, read when a pixel is
// accepted and written when that pixel leaves the first stage, so it
// sustains one pixel per cycle.
// rst_n is synchronous; it clears counters, the left pixel and the valid
// bits. The line buffer needs no clearing pass.
// A stall on the output only holds the pipeline once every stage is full;
// empty stages keep taking transactions.
module rgb_to_yuv420_converter_core
  import r2y_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LPROD_W    = ROW_W + LSTRIDE_W;
  localparam int CPROD_W    = ROW_W + CSTRIDE_W;

  // Stage 1: the pixel after acceptance, waiting for its line buffer entry.
  typedef struct packed {
    in_item_t         pix;
    pair_t            pair;
    logic             wr_line;
    logic             chroma;
    logic             row_odd;
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } s1_t;

  // Stage 2: luma and addresses done, block averages ready for Cb and Cr.
  typedef struct packed {
    logic [COMP_W-1:0]        luma;
    logic [LUMA_ADDR_W-1:0]   laddr;
    logic                     chroma;
    logic [COMP_W-1:0]        avg_r;
    logic [COMP_W-1:0]        avg_g;
    logic [COMP_W-1:0]        avg_b;
    logic [CHROMA_ADDR_W-1:0] caddr;
    logic                     last;
  } s2_t;

  cfg_t cfg;

  r2y_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow control. Each stage loads when it is empty or when its
  // content moves on in the same cycle.
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_load, s2_load, s1_load, s1_adv, accept;

  assign out_load = !out_v_r || !out_stall;
  assign s2_load  = !s2_v_r || out_load;
  assign s1_load  = !s1_v_r || s2_load;
  assign s1_adv   = s1_v_r && s2_load;
  assign accept   = in_valid && s1_load;
  assign in_stall = !s1_load;

  always_comb begin
    out_v_nxt = out_load ? s2_v_r : out_v_r;
    s2_v_nxt  = s2_load ? s1_v_r : s2_v_r;
    s1_v_nxt  = s1_load ? accept : s1_v_r;
  end

  // Raster position and the held left pixel of a horizontal pair.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  in_item_t         left_r, left_nxt;
  logic             col_last, row_last, col_odd, row_odd, pair_end;
  pair_t            pair_in;

  // A counter at or past the last column or row counts as being on it, so a
  // size change in the middle of a frame still ends the row or frame.
  assign col_last = DIM_W'(col_r) >= cfg.width_last;
  assign row_last = DIM_W'(row_r) >= cfg.height_last;
  assign col_odd  = col_r[0];
  assign row_odd  = row_r[0];
  // A pair ends on an odd column, or on a lone last column at an odd width.
  assign pair_end = col_odd || col_last;

  always_comb begin
    pair_in.red   = PAIR_W'(in_data.red);
    pair_in.green = PAIR_W'(in_data.green);
    pair_in.blue  = PAIR_W'(in_data.blue);
    if (col_odd) begin
      pair_in.red   = pair_in.red + PAIR_W'(left_r.red);
      pair_in.green = pair_in.green + PAIR_W'(left_r.green);
      pair_in.blue  = pair_in.blue + PAIR_W'(left_r.blue);
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (!pair_end) begin
        left_nxt = in_data;
      end
    end
  end

  // Line buffer of pair sums, one entry per two columns. Even rows but the last
  // write the pair sum of stage 1; odd rows read it back and add their own pair
  // to finish the 2x2 block, while a last even row uses its own pair alone.
  s1_t              s1_r, s1_nxt;
  logic [IDX_W-1:0] rd_idx;
  logic             ram_we;
  pair_t            ram_rdata;
  logic             fwd_hit_r, fwd_hit_nxt;
  pair_t            fwd_data_r, fwd_data_nxt;

  assign rd_idx = IDX_W'(col_r >> 1);
  assign ram_we = s1_adv && s1_r.wr_line;

  r2y_ram #(
    .DATA_W ($bits(pair_t)),
    .DEPTH  (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_r.idx),
    .wdata (s1_r.pair),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_nxt       = s1_r;
    fwd_hit_nxt  = fwd_hit_r;
    fwd_data_nxt = fwd_data_r;
    if (s1_load) begin
      s1_nxt.pix     = in_data;
      s1_nxt.pair    = pair_in;
      s1_nxt.wr_line = pair_end && !row_odd && !row_last;
      s1_nxt.chroma  = pair_end && (row_odd || row_last);
      s1_nxt.row_odd = row_odd;
      s1_nxt.idx     = rd_idx;
      s1_nxt.col     = col_r;
      s1_nxt.row     = row_r;
      s1_nxt.last    = col_last && row_last;
      // The RAM returns the old word when the same entry is written in the
      // read cycle; keep the new word to replace it.
      fwd_hit_nxt    = ram_we && (s1_r.idx == rd_idx);
      fwd_data_nxt   = s1_r.pair;
    end
  end

  // Stage 1 arithmetic: block sums, averages, luma and both addresses.
  pair_t                line_word;
  logic [QUAD_W-1:0]    sum_r, sum_g, sum_b;
  logic [MATH_W-1:0]    y_sum;
  logic [LPROD_W-1:0]   lprod;
  logic [CPROD_W-1:0]   cprod;
  s2_t                  s2_r, s2_nxt;

  assign line_word = fwd_hit_r ? fwd_data_r : ram_rdata;

  always_comb begin
    sum_r = QUAD_W'(s1_r.pair.red);
    sum_g = QUAD_W'(s1_r.pair.green);
    sum_b = QUAD_W'(s1_r.pair.blue);
    if (s1_r.row_odd) begin
      sum_r = sum_r + QUAD_W'(line_word.red);
      sum_g = sum_g + QUAD_W'(line_word.green);
      sum_b = sum_b + QUAD_W'(line_word.blue);
    end
  end

  assign y_sum = Y_R_COEF * MATH_W'(s1_r.pix.red) + Y_G_COEF * MATH_W'(s1_r.pix.green)
               + Y_B_COEF * MATH_W'(s1_r.pix.blue) + ROUND_OFS;

  assign lprod = LPROD_W'(s1_r.row) * LPROD_W'(cfg.luma_stride);
  assign cprod = CPROD_W'(s1_r.row >> 1) * CPROD_W'(cfg.chroma_stride);

  always_comb begin
    s2_nxt = s2_r;
    if (s2_load) begin
      s2_nxt.luma   = y_sum[MATH_W-1:MATH_W-COMP_W] + LUMA_OFS;
      s2_nxt.laddr  = LUMA_ADDR_W'(lprod) + LUMA_ADDR_W'(s1_r.col);
      s2_nxt.chroma = s1_r.chroma;
      // Edge blocks with fewer pixels are still divided by four.
      s2_nxt.avg_r  = sum_r[QUAD_W-1:2];
      s2_nxt.avg_g  = sum_g[QUAD_W-1:2];
      s2_nxt.avg_b  = sum_b[QUAD_W-1:2];
      s2_nxt.caddr  = s1_r.chroma
                    ? CHROMA_ADDR_W'(cprod) + CHROMA_ADDR_W'(s1_r.col >> 1) : '0;
      s2_nxt.last   = s1_r.last;
    end
  end

  // Stage 2: Cb and Cr, then the output register.
  logic [COMP_W-1:0] cb, cr;
  out_item_t         out_r, out_nxt;

  r2y_chroma u_chroma (
    .en    (s2_r.chroma),
    .avg_r (s2_r.avg_r),
    .avg_g (s2_r.avg_g),
    .avg_b (s2_r.avg_b),
    .cb    (cb),
    .cr    (cr)
  );

  always_comb begin
    out_nxt = out_r;
    if (out_load) begin
      out_nxt.luma           = s2_r.luma;
      out_nxt.luma_address   = s2_r.laddr;
      out_nxt.chroma_valid   = s2_r.chroma;
      out_nxt.chroma_u       = cb;
      out_nxt.chroma_v       = cr;
      out_nxt.chroma_address = s2_r.caddr;
      out_nxt.frame_last     = s2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      left_r    <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
      out_v_r   <= out_v_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      left_r    <= left_nxt;
      fwd_hit_r <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    out_r      <= out_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
